[rtl/core/ivalloc_pkg.sv]
// shared types, codes and default sizes for the interrupt vector allocator
// no dependencies; compile first

package ivalloc_pkg;

    // fixed field widths
    localparam int CMD_BITS   = 2;
    localparam int VEC_BITS   = 6;
    localparam int HIN_BITS   = 32;
    localparam int STAT_BITS  = 2;
    localparam int ENTRY_BITS = 2;

    // default sizes for the top level parameters
    localparam int DEF_NUM_VECTORS  = 64;
    localparam int DEF_ALLOC_FIRST  = 16;
    localparam int DEF_ALLOC_LAST   = 63;
    localparam int DEF_HANDLER_BITS = 32;

    typedef logic [CMD_BITS-1:0]   t_cmd;
    typedef logic [VEC_BITS-1:0]   t_vec;
    typedef logic [HIN_BITS-1:0]   t_handler;
    typedef logic [STAT_BITS-1:0]  t_status;
    typedef logic [ENTRY_BITS-1:0] t_entry;

    // commands
    localparam t_cmd CMD_ALLOC  = 2'd0;
    localparam t_cmd CMD_CLAIM  = 2'd1;
    localparam t_cmd CMD_FREE   = 2'd2;
    localparam t_cmd CMD_LOOKUP = 2'd3;

    // result status
    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_ALREADY   = 2'd1;
    localparam t_status STAT_NOT_ALLOC = 2'd2;
    localparam t_status STAT_NONE_FREE = 2'd3;

    // entry states
    localparam t_entry ENT_RESERVED  = 2'd0;
    localparam t_entry ENT_FREE      = 2'd1;
    localparam t_entry ENT_ALLOCATED = 2'd2;

endpackage

[rtl/core/ivalloc_if.sv]
// request and result channel interfaces of the interrupt vector allocator
// depends on ivalloc_pkg

interface ivalloc_cmd_if import ivalloc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cmd     command;
    t_vec     vector;
    t_handler handler_value;

    modport source (output valid, output command, output vector, output handler_value,
                    input ready);
    modport sink   (input valid, input command, input vector, input handler_value,
                    output ready);
endinterface

interface ivalloc_rsp_if import ivalloc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_status  status;
    t_vec     vector_out;
    t_handler handler_out;
    logic     used_default;

    modport source (output valid, output status, output vector_out, output handler_out,
                    output used_default, input ready);
    modport sink   (input valid, input status, input vector_out, input handler_out,
                    input used_default, output ready);
endinterface

[rtl/core/ivalloc_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies

module ivalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/interrupt_vector_allocator_top.sv]
// interrupt vector allocator: sequencer, entry state ram and handler ram
// depends on ivalloc_pkg, ivalloc_if and ivalloc_ram
//
//  channel    dir  handshake      payload
//  i_cmd      in   valid/ready    command, vector, handler_value
//  o_rsp      out  valid/ready    status, vector_out, handler_out, used_default
//  i_cfg_*    in   write enable   default_handler (32 bits)
//
// claim, free and lookup are accepted with a ram read, then finish in the
// execute step, a read-modify-write for claim and free. allocate scans the
// state ram one entry a cycle from ALLOC_FIRST, at most the allocatable range.
// after reset a clearing pass writes every entry with i_cmd.ready low;
// configuration writes are taken at any time.
// a result waits in the output register; a full, stalled output holds the
// sequencer at its last step, and no new item is accepted until it moves.

module interrupt_vector_allocator_top import ivalloc_pkg::*; #(
    parameter int NUM_VECTORS  = DEF_NUM_VECTORS,
    parameter int ALLOC_FIRST  = DEF_ALLOC_FIRST,
    parameter int ALLOC_LAST   = DEF_ALLOC_LAST,
    parameter int HANDLER_BITS = DEF_HANDLER_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ivalloc_cmd_if.sink        i_cmd,
    ivalloc_rsp_if.source      o_rsp,
    input  logic               i_cfg_we,
    input  logic [HIN_BITS-1:0] i_cfg_data
);

    localparam int AW        = $clog2(NUM_VECTORS);
    localparam int ALLOC_END = (ALLOC_LAST > NUM_VECTORS - 1) ? NUM_VECTORS - 1 : ALLOC_LAST;
    localparam bit RANGE_OK  = (ALLOC_FIRST <= ALLOC_END);
    localparam logic [AW-1:0] SCAN_FIRST = RANGE_OK ? AW'(ALLOC_FIRST) : '0;
    localparam logic [AW-1:0] SCAN_LAST  = AW'(ALLOC_END);
    localparam logic [AW-1:0] LAST_IDX   = AW'(NUM_VECTORS - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [AW-1:0]           r_idx, n_idx;
    t_cmd                    r_cmd;
    t_vec                    r_vec;
    logic [HANDLER_BITS-1:0] r_hval;
    logic                    r_in_table;
    t_handler                r_default;

    logic                    r_out_valid;
    t_status                 r_status;
    t_vec                    r_vout;
    t_handler                r_hout;
    logic                    r_used;

    logic                    in_acc;
    logic                    out_free;
    logic                    done;
    t_status                 res_status;
    t_vec                    res_vout;
    t_handler                res_hout;
    logic                    res_used;

    logic [AW-1:0]           raddr;
    logic                    st_we;
    t_entry                  st_wdata;
    t_entry                  st_rdata;
    logic                    hd_we;
    logic [HANDLER_BITS-1:0] hd_wdata;
    logic [HANDLER_BITS-1:0] hd_rdata;
    logic [HANDLER_BITS-1:0] look_h;
    logic [31:0]             idx_ext;
    t_entry                  clear_val;

    ivalloc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(NUM_VECTORS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_idx),
        .i_wdata (st_wdata),
        .i_raddr (raddr),
        .o_rdata (st_rdata)
    );

    ivalloc_ram #(.WIDTH(HANDLER_BITS), .DEPTH(NUM_VECTORS)) u_handler_ram (
        .i_clk   (i_clk),
        .i_we    (hd_we),
        .i_waddr (r_idx),
        .i_wdata (hd_wdata),
        .i_raddr (raddr),
        .o_rdata (hd_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // reset value of the entry being cleared, and the handler a lookup sees (zero outside the table)
    always_comb begin
        idx_ext   = 32'(r_idx);
        clear_val = (RANGE_OK && idx_ext >= 32'(ALLOC_FIRST) && idx_ext <= 32'(ALLOC_END))
                    ? ENT_FREE : ENT_RESERVED;
        look_h    = r_in_table ? hd_rdata : '0;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        raddr      = r_idx;
        st_we      = 1'b0;
        st_wdata   = ENT_ALLOCATED;
        hd_we      = 1'b0;
        hd_wdata   = r_hval;
        done       = 1'b0;
        res_status = STAT_OK;
        res_vout   = r_vec;
        res_hout   = '0;
        res_used   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                st_we    = 1'b1;
                st_wdata = clear_val;
                hd_we    = 1'b1;
                hd_wdata = '0;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_cmd.command == CMD_ALLOC) begin
                        n_idx   = SCAN_FIRST;
                        raddr   = SCAN_FIRST;
                        n_state = S_SCAN;
                    end else begin
                        n_idx   = AW'(i_cmd.vector);
                        raddr   = AW'(i_cmd.vector);
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                if (!RANGE_OK) begin
                    res_status = STAT_NONE_FREE;
                    res_vout   = '0;
                    done       = out_free;
                end else if (st_rdata == ENT_FREE) begin
                    res_status = STAT_OK;
                    res_vout   = VEC_BITS'(r_idx);
                    done       = out_free;
                    st_we      = out_free;
                    hd_we      = out_free;
                end else if (r_idx == SCAN_LAST) begin
                    res_status = STAT_NONE_FREE;
                    res_vout   = '0;
                    done       = out_free;
                end else begin
                    n_idx = r_idx + AW'(1);
                    raddr = r_idx + AW'(1);
                end
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                done = out_free;
                case (r_cmd)
                    CMD_CLAIM: begin
                        if (!r_in_table) begin
                            res_status = STAT_NOT_ALLOC;
                        end else if (st_rdata == ENT_ALLOCATED) begin
                            res_status = STAT_ALREADY;
                        end else begin
                            st_we = out_free;
                            // a zero handler leaves the stored one in place
                            hd_we = out_free && (r_hval != '0);
                        end
                    end
                    CMD_FREE: begin
                        if (!r_in_table || st_rdata != ENT_ALLOCATED) begin
                            res_status = STAT_NOT_ALLOC;
                        end else begin
                            st_we    = out_free;
                            st_wdata = ENT_FREE;
                            hd_we    = out_free;
                            hd_wdata = '0;
                        end
                    end
                    CMD_LOOKUP: begin
                        if (look_h != '0) begin
                            res_hout = HIN_BITS'(look_h);
                        end else begin
                            res_hout = r_default;
                            res_used = 1'b1;
                        end
                    end
                    default: begin
                        res_status = STAT_OK;
                    end
                endcase
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_default   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_default <= i_cfg_data;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd      <= i_cmd.command;
            r_vec      <= i_cmd.vector;
            r_hval     <= HANDLER_BITS'(i_cmd.handler_value);
            r_in_table <= (32'(i_cmd.vector) < 32'(NUM_VECTORS));
        end
        if (done) begin
            r_status <= res_status;
            r_vout   <= res_vout;
            r_hout   <= res_hout;
            r_used   <= res_used;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.vector_out   = r_vout;
    assign o_rsp.handler_out  = r_hout;
    assign o_rsp.used_default = r_used;

`ifndef SYNTH
    // the scan never leaves the allocatable range
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && RANGE_OK) |-> (r_idx >= SCAN_FIRST && r_idx <= SCAN_LAST))
        else $error("allocate scan index outside range");

    // an accepted item always starts the execute step or an allocate scan
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC || r_state == S_SCAN))
        else $error("accepted item did not start");

    // the clearing pass runs to the last entry before taking items
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_idx != LAST_IDX) |=> (r_state == S_CLEAR))
        else $error("clearing pass ended early");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !done)
        else $error("result overwritten while stalled");
`endif

endmodule
